### rtl/one_button_dimmer_fsm_top_defines.svh
// Assertion macros for the one-button dimmer RTL.
// Each macro expects clk and rst_n in scope and takes a label, an
// antecedent, a consequent and a message string.
`ifndef ONE_BUTTON_DIMMER_FSM_TOP_DEFINES_SVH
`define ONE_BUTTON_DIMMER_FSM_TOP_DEFINES_SVH

// Same-cycle implication.
`define OBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types, codes and reset values for the one-button dimmer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obd_pkg;

    localparam int CNT_W   = 8;
    localparam int LEVEL_W = 4;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 8;

    // Mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] CODE_DOWN = 3'd0;
    localparam logic [MODE_W-1:0] CODE_UP   = 3'd1;
    localparam logic [MODE_W-1:0] CODE_FALL = 3'd2;
    localparam logic [MODE_W-1:0] CODE_MIN  = 3'd3;
    localparam logic [MODE_W-1:0] CODE_RISE = 3'd4;
    localparam logic [MODE_W-1:0] CODE_MAX  = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0]   RST_LONG_PRESS = 8'd10;
    localparam logic [CNT_W-1:0]   RST_STEP       = 8'd10;
    localparam logic [CNT_W-1:0]   RST_PULSE      = 8'd2;
    localparam logic [CNT_W-1:0]   RST_BLINK      = 8'd1;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_STEPS = 4'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LONG_PRESS  = 3'd0,
        REG_STEP        = 3'd1,
        REG_PULSE       = 3'd2,
        REG_BLINK       = 3'd3,
        REG_LEVEL_STEPS = 3'd4
    } reg_idx_t;

    // Dimmer mode, one-hot
    typedef enum logic [5:0] {
        MODE_DOWN = 6'b000001,
        MODE_UP   = 6'b000010,
        MODE_FALL = 6'b000100,
        MODE_MIN  = 6'b001000,
        MODE_RISE = 6'b010000,
        MODE_MAX  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [CNT_W-1:0]   long_press;
        logic [CNT_W-1:0]   step;
        logic [CNT_W-1:0]   pulse;
        logic [CNT_W-1:0]   blink;
        logic [LEVEL_W-1:0] level_steps;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_level;
        logic               orange_led;
        logic               blue_led;
        logic [MODE_W-1:0]  mode;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_DOWN: c = CODE_DOWN;
            MODE_UP:   c = CODE_UP;
            MODE_FALL: c = CODE_FALL;
            MODE_MIN:  c = CODE_MIN;
            MODE_RISE: c = CODE_RISE;
            MODE_MAX:  c = CODE_MAX;
            default:   c = CODE_UP;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/obd_tick_if.sv
// ----------------------------------------------------------------------------
// obd_tick_if
// Tick channel: one beat per time tick with the sampled button level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface obd_tick_if;
    logic valid;
    logic ready;
    logic button;

    modport source (output valid, output button, input ready);
    modport sink   (input valid, input button, output ready);
endinterface

`default_nettype wire

### rtl/obd_result_if.sv
// ----------------------------------------------------------------------------
// obd_result_if
// Result channel: brightness level, indicator LEDs and mode code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface obd_result_if;
    import obd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pwm_level;
    logic               orange_led;
    logic               blue_led;
    logic [MODE_W-1:0]  mode;

    modport source (output valid, output pwm_level, output orange_led,
                    output blue_led, output mode, input ready);
    modport sink   (input valid, input pwm_level, input orange_led,
                    input blue_led, input mode, output ready);
endinterface

`default_nettype wire

### rtl/obd_cfg.sv
// ----------------------------------------------------------------------------
// obd_cfg
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obd_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [obd_pkg::IDX_W-1:0] wr_index,
    input  wire logic [obd_pkg::DATA_W-1:0] wr_data,
    output obd_pkg::cfg_t                  cfg
);
    import obd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_LONG_PRESS:  cfg_next.long_press  = wr_data[CNT_W-1:0];
                REG_STEP:        cfg_next.step        = wr_data[CNT_W-1:0];
                REG_PULSE:       cfg_next.pulse       = wr_data[CNT_W-1:0];
                REG_BLINK:       cfg_next.blink       = wr_data[CNT_W-1:0];
                REG_LEVEL_STEPS: cfg_next.level_steps = wr_data[LEVEL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press  <= RST_LONG_PRESS;
            cfg_reg.step        <= RST_STEP;
            cfg_reg.pulse       <= RST_PULSE;
            cfg_reg.blink       <= RST_BLINK;
            cfg_reg.level_steps <= RST_LEVEL_STEPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/obd_core.sv
// ----------------------------------------------------------------------------
// obd_core
// Dimmer state and the per-tick update: press timing, mode rules, step
// pulse, level stepping and blink. Produces the post-tick result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "one_button_dimmer_fsm_top_defines.svh"

module obd_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire logic     button,
    input  wire obd_pkg::cfg_t cfg,
    output obd_pkg::result_t res
);
    import obd_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               bprev_reg;
    logic [CNT_W-1:0]   press_reg, press_next;
    logic [CNT_W-1:0]   period_reg, period_next;
    logic [CNT_W-1:0]   pulse_reg, pulse_next;
    logic               orange_reg, orange_next;
    logic               blue_reg, blue_next;

    // One tick of update
    always_comb
    begin
        logic  rel;
        logic  is_long;
        logic  below_full;
        logic  nonzero;
        logic  enter;
        logic  can_step;
        mode_t tgt;

        mode_next   = mode_reg;
        level_next  = level_reg;
        press_next  = press_reg;
        period_next = period_reg;
        pulse_next  = pulse_reg;
        orange_next = orange_reg;
        blue_next   = blue_reg;
        can_step    = 1'b0;

        rel = !button && bprev_reg;

        // press timer, restarts on a press edge, saturates
        if (button)
        begin
            if (!bprev_reg)
                press_next = {{(CNT_W-1){1'b0}}, 1'b1};
            else if (press_next != CNT_MAX)
                press_next = press_next + 1'b1;
        end

        is_long    = press_next >= cfg.long_press;
        below_full = level_reg < cfg.level_steps;
        nonzero    = level_reg != '0;

        // mode rules, first match wins
        enter = 1'b0;
        tgt   = mode_reg;
        if (button || rel)
        begin
            enter = 1'b1;
            if (rel && !is_long && mode_reg == MODE_UP)
                tgt = MODE_DOWN;
            else if (rel && !is_long && mode_reg == MODE_DOWN)
                tgt = MODE_UP;
            else if (is_long && mode_reg == MODE_UP && below_full)
                tgt = MODE_RISE;
            else if (is_long && mode_reg == MODE_DOWN && nonzero)
                tgt = MODE_FALL;
            else if (mode_reg == MODE_FALL && button && !nonzero)
                tgt = MODE_MIN;
            else if (mode_reg == MODE_RISE && button && !below_full)
                tgt = MODE_MAX;
            else if (mode_reg == MODE_MAX && !button)
                tgt = MODE_DOWN;
            else if (mode_reg == MODE_MIN && !button)
                tgt = MODE_UP;
            else if (mode_reg == MODE_RISE && !button && below_full)
                tgt = MODE_UP;
            else if (mode_reg == MODE_FALL && !button && nonzero)
                tgt = MODE_DOWN;
            else
                enter = 1'b0;
        end

        // entry actions
        if (enter)
        begin
            mode_next = tgt;
            case (tgt)
                MODE_UP:
                begin
                    orange_next = 1'b0;
                    blue_next   = 1'b1;
                    pulse_next  = '0;
                end
                MODE_DOWN:
                begin
                    orange_next = 1'b1;
                    blue_next   = 1'b0;
                    pulse_next  = '0;
                end
                default:
                begin
                    period_next = '0;
                    if (tgt inside {MODE_MIN, MODE_MAX})
                        pulse_next = '0;
                end
            endcase
        end

        // pending pulse
        if (pulse_next != '0)
        begin
            pulse_next = pulse_next - 1'b1;
            if (pulse_next == '0)
                blue_next = 1'b1;
        end

        // mode action: level step or blink
        case (mode_next)
            MODE_RISE, MODE_FALL:
            begin
                if (period_next != CNT_MAX)
                    period_next = period_next + 1'b1;
                if (period_next >= cfg.step)
                begin
                    period_next = '0;
                    can_step = (mode_next == MODE_RISE) ? below_full : nonzero;
                    if (can_step)
                    begin
                        level_next = (mode_next == MODE_RISE) ? level_reg + 1'b1
                                                              : level_reg - 1'b1;
                        blue_next  = 1'b0;
                        pulse_next = (cfg.pulse == '0) ? {{(CNT_W-1){1'b0}}, 1'b1}
                                                       : cfg.pulse;
                    end
                end
            end
            MODE_MIN, MODE_MAX:
            begin
                if (period_next != CNT_MAX)
                    period_next = period_next + 1'b1;
                if (period_next >= cfg.blink)
                begin
                    period_next = '0;
                    blue_next   = !blue_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    // State registers, advance once per tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_UP;
            level_reg  <= '0;
            bprev_reg  <= 1'b0;
            press_reg  <= '0;
            period_reg <= '0;
            pulse_reg  <= '0;
            orange_reg <= 1'b0;
            blue_reg   <= 1'b1;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            bprev_reg  <= button;
            press_reg  <= press_next;
            period_reg <= period_next;
            pulse_reg  <= pulse_next;
            orange_reg <= orange_next;
            blue_reg   <= blue_next;
        end
    end

    // Result after this tick
    assign res.pwm_level  = level_next;
    assign res.orange_led = orange_next;
    assign res.blue_led   = blue_next;
    assign res.mode       = mode_code(mode_next);

    // Checks
    `OBD_ASSERT_NOW(a_up_leds, mode_reg == MODE_UP, !orange_reg && blue_reg,
        "up mode LEDs wrong")
    `OBD_ASSERT_NOW(a_down_leds, mode_reg == MODE_DOWN, orange_reg && !blue_reg,
        "down mode LEDs wrong")
    `OBD_ASSERT_NOW(a_pulse_mode, pulse_reg != '0,
        mode_reg == MODE_RISE || mode_reg == MODE_FALL,
        "pulse pending outside rise or fall")
    `OBD_ASSERT_NEXT(a_level_hold,
        !step || !(mode_next == MODE_RISE || mode_next == MODE_FALL),
        $stable(level_reg), "level moved outside rise or fall")

endmodule

`default_nettype wire

### rtl/one_button_dimmer_fsm_top.sv
// One-button dimmer controller.
// Channels: tick (sink) carries one beat per time tick with the sampled
// button level; result (source) returns one beat per tick with the
// brightness level, orange and blue LEDs and the mode code.
// Configuration: wr_en/wr_index/wr_data write one of five registers per
// cycle (long press, step, pulse, blink periods and level steps); write
// only while no tick is in flight.
// Path: an accepted tick is held in the input register, then the core update
// writes its result into the result register, where it can be taken.
// Throughput: one tick per cycle while result is not back-pressured; the
// state update lies between the input register and the result register.
// Stall: when result is not taken, the result register holds and the
// input register keeps one more tick; tick.ready drops once both are full.
// Reset: mode up, level 0, orange off, blue on, counters cleared,
// registers at their defaults; both pipeline registers empty.
// ----------------------------------------------------------------------------
// one_button_dimmer_fsm_top
// Top level: input register, dimmer core, result register, config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module one_button_dimmer_fsm_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [obd_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [obd_pkg::DATA_W-1:0] wr_data,
    obd_tick_if.sink                        tick,
    obd_result_if.source                    result
);
    import obd_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t res_reg;
    logic    in_v_reg, in_v_next;
    logic    btn_reg;
    logic    res_v_reg, res_v_next;
    logic    adv;
    logic    fire;

    obd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    obd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .button (btn_reg),
        .cfg    (cfg),
        .res    (core_res)
    );

    // Handshake
    assign adv        = !res_v_reg || result.ready;
    assign fire       = in_v_reg && adv;
    assign tick.ready = !in_v_reg || adv;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (tick.valid && tick.ready)
            in_v_next = 1'b1;
        else if (fire)
            in_v_next = 1'b0;

        res_v_next = res_v_reg;
        if (fire)
            res_v_next = 1'b1;
        else if (result.ready)
            res_v_next = 1'b0;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            res_v_reg <= res_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
            btn_reg <= tick.button;
        if (fire)
            res_reg <= core_res;
    end

    assign result.valid      = res_v_reg;
    assign result.pwm_level  = res_reg.pwm_level;
    assign result.orange_led = res_reg.orange_led;
    assign result.blue_led   = res_reg.blue_led;
    assign result.mode       = res_reg.mode;

endmodule

`default_nettype wire

### sim/one_button_dimmer_fsm_top_tb.sv
// ----------------------------------------------------------------------------
// one_button_dimmer_fsm_top_tb
// Self-checking bench for the one-button dimmer: button ticks go in on the
// tick channel, and a per-tick dimmer predictor checks every result
// beat. Both channels idle at random, and the config is changed between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_button_dimmer_fsm_top_tb;
    import obd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 50;

    logic                clk;
    logic                rst_n;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_index;
    logic [DATA_W-1:0]   wr_data;

    obd_tick_if   tick_ch ();
    obd_result_if res_ch ();

    one_button_dimmer_fsm_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .tick     (tick_ch),
        .result   (res_ch)
    );

    // Button levels waiting to be sent, and dimmer outputs waiting to arrive
    logic    button_ticks_q[$];
    result_t dimmer_outputs_q[$];

    // Predictor copy of config and dimmer state
    cfg_t              dim_cfg;
    logic [MODE_W-1:0] dim_mode;
    logic [LEVEL_W-1:0] dim_level;
    logic              dim_prev;
    logic [CNT_W-1:0]  dim_press;
    logic [CNT_W-1:0]  dim_period;
    logic [CNT_W-1:0]  dim_pulse;
    logic              dim_orange;
    logic              dim_blue;

    int      mismatch_cnt;
    int      idle_cycles;
    int      src_gap;
    int      sink_gap;
    bit      src_calm;
    bit      sink_calm;
    result_t next_want;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Dimmer predictor
    // ------------------------------------------------------------------
    function automatic void reset_dimmer();
        dim_cfg.long_press  = RST_LONG_PRESS;
        dim_cfg.step        = RST_STEP;
        dim_cfg.pulse       = RST_PULSE;
        dim_cfg.blink       = RST_BLINK;
        dim_cfg.level_steps = RST_LEVEL_STEPS;
        dim_mode   = CODE_UP;
        dim_level  = '0;
        dim_prev   = 1'b0;
        dim_press  = '0;
        dim_period = '0;
        dim_pulse  = '0;
        dim_orange = 1'b0;
        dim_blue   = 1'b1;
    endfunction

    // Mode entry: LEDs and pulse clear for up/down, period restart for the others, pulse clear for min/max
    function automatic void enter_dimmer_mode(input logic [MODE_W-1:0] m);
        dim_mode = m;
        if (m == CODE_UP)
        begin
            dim_orange = 1'b0;
            dim_blue   = 1'b1;
            dim_pulse  = '0;
        end
        else if (m == CODE_DOWN)
        begin
            dim_orange = 1'b1;
            dim_blue   = 1'b0;
            dim_pulse  = '0;
        end
        else
        begin
            dim_period = '0;
            if (m == CODE_MIN || m == CODE_MAX)
                dim_pulse = '0;
        end
    endfunction

    // Transition rules, first match wins
    function automatic void pick_dimmer_mode(input logic held, input logic rel);
        logic is_long;
        logic below_full;
        logic at_zero;
        is_long    = dim_press >= dim_cfg.long_press;
        below_full = dim_level < dim_cfg.level_steps;
        at_zero    = dim_level == '0;
        if (rel && !is_long && dim_mode == CODE_UP)
            enter_dimmer_mode(CODE_DOWN);
        else if (rel && !is_long && dim_mode == CODE_DOWN)
            enter_dimmer_mode(CODE_UP);
        else if (is_long && dim_mode == CODE_UP && below_full)
            enter_dimmer_mode(CODE_RISE);
        else if (is_long && dim_mode == CODE_DOWN && !at_zero)
            enter_dimmer_mode(CODE_FALL);
        else if (dim_mode == CODE_FALL && held && at_zero)
            enter_dimmer_mode(CODE_MIN);
        else if (dim_mode == CODE_RISE && held && !below_full)
            enter_dimmer_mode(CODE_MAX);
        else if (dim_mode == CODE_MAX && !held)
            enter_dimmer_mode(CODE_DOWN);
        else if (dim_mode == CODE_MIN && !held)
            enter_dimmer_mode(CODE_UP);
        else if (dim_mode == CODE_RISE && !held && below_full)
            enter_dimmer_mode(CODE_UP);
        else if (dim_mode == CODE_FALL && !held && !at_zero)
            enter_dimmer_mode(CODE_DOWN);
    endfunction

    // One tick: press counter, rules, pulse countdown, step or blink
    function automatic result_t advance_dimmer(input logic btn);
        result_t r;
        logic    rel;
        logic    can_step;
        rel = !btn && dim_prev;
        if (btn)
        begin
            if (!dim_prev)
                dim_press = 8'd1;
            else if (dim_press != CNT_MAX)
                dim_press = dim_press + 1'b1;
        end
        if (btn || rel)
            pick_dimmer_mode(btn, rel);
        if (dim_pulse != '0)
        begin
            dim_pulse = dim_pulse - 1'b1;
            if (dim_pulse == '0)
                dim_blue = 1'b1;
        end
        if (dim_mode == CODE_RISE || dim_mode == CODE_FALL)
        begin
            if (dim_period != CNT_MAX)
                dim_period = dim_period + 1'b1;
            if (dim_period >= dim_cfg.step)
            begin
                dim_period = '0;
                if (dim_mode == CODE_RISE)
                    can_step = dim_level < dim_cfg.level_steps;
                else
                    can_step = dim_level != '0;
                if (can_step)
                begin
                    if (dim_mode == CODE_RISE)
                        dim_level = dim_level + 1'b1;
                    else
                        dim_level = dim_level - 1'b1;
                    dim_blue  = 1'b0;
                    dim_pulse = (dim_cfg.pulse != '0) ? dim_cfg.pulse : 8'd1;
                end
            end
        end
        else if (dim_mode == CODE_MIN || dim_mode == CODE_MAX)
        begin
            if (dim_period != CNT_MAX)
                dim_period = dim_period + 1'b1;
            if (dim_period >= dim_cfg.blink)
            begin
                dim_period = '0;
                dim_blue   = ~dim_blue;
            end
        end
        dim_prev = btn;
        r.pwm_level  = dim_level;
        r.orange_led = dim_orange;
        r.blue_led   = dim_blue;
        r.mode       = dim_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < REPORT_CAP)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Mostly back to back, sometimes short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic hold_button(input logic lvl, input int n);
        repeat (n) button_ticks_q.push_back(lvl);
    endtask

    task automatic wait_drained();
        while (button_ticks_q.size() != 0 || tick_ch.valid || dimmer_outputs_q.size() != 0)
            @(negedge clk);
        // pipeline is two deep
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_LONG_PRESS:  dim_cfg.long_press  = val;
            REG_STEP:        dim_cfg.step        = val;
            REG_PULSE:       dim_cfg.pulse       = val;
            REG_BLINK:       dim_cfg.blink       = val;
            REG_LEVEL_STEPS: dim_cfg.level_steps = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Full reprogram once the block has gone quiet
    task automatic load_config(input logic [7:0] lp, input logic [7:0] st,
                               input logic [7:0] pu, input logic [7:0] bl,
                               input logic [7:0] steps);
        wait_drained();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_STEP, st);
        write_reg(REG_PULSE, pu);
        write_reg(REG_BLINK, bl);
        write_reg(REG_LEVEL_STEPS, steps);
        @(posedge clk);
        wr_en <= 1'b0;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [7:0] pick_period(input int hi);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd255;
        if (r == 1)
            return 8'd1;
        return 8'($urandom_range(1, hi));
    endfunction

    // Press patterns: short taps, long holds through rise/fall, and noise
    task automatic queue_presses(input int budget);
        int sent;
        int lp;
        int span;
        int hold;
        int gap;
        int pick;
        sent = 0;
        while (sent < budget)
        begin
            lp   = (dim_cfg.long_press == '0) ? 1 : int'(dim_cfg.long_press);
            span = (int'(dim_cfg.step) + 1) * (int'(dim_cfg.level_steps) + 2);
            if (span > 200)
                span = 200;
            pick = $urandom_range(0, 9);
            if (pick < 3)
                hold = (lp > 1) ? $urandom_range(1, lp - 1) : 1;
            else if (pick < 8)
                hold = lp + $urandom_range(0, span);
            else
            begin
                hold = 0;
                repeat ($urandom_range(1, 8))
                begin
                    button_ticks_q.push_back(1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            gap = $urandom_range(1, 6);
            hold_button(1'b1, hold);
            hold_button(1'b0, gap);
            sent += hold + gap;
        end
    endtask

    // ------------------------------------------------------------------
    // Tick driver: predicts each accepted beat
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid  <= 1'b0;
            tick_ch.button <= 1'b0;
            src_gap = 0;
        end
        else if (!tick_ch.valid || tick_ch.ready)
        begin
            if (tick_ch.valid)
                dimmer_outputs_q.push_back(advance_dimmer(tick_ch.button));
            if (src_gap > 0)
            begin
                src_gap--;
                tick_ch.valid <= 1'b0;
            end
            else if (button_ticks_q.size() != 0)
            begin
                tick_ch.button <= button_ticks_q.pop_front();
                tick_ch.valid  <= 1'b1;
                src_gap = pick_gap(src_calm);
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (dimmer_outputs_q.size() == 0)
                    report_mismatch("result beat with nothing expected",
                                    int'(res_ch.mode), 0);
                else
                begin
                    next_want = dimmer_outputs_q.pop_front();
                    if (res_ch.pwm_level !== next_want.pwm_level)
                        report_mismatch("pwm_level", int'(res_ch.pwm_level),
                                        int'(next_want.pwm_level));
                    if (res_ch.orange_led !== next_want.orange_led)
                        report_mismatch("orange_led", int'(res_ch.orange_led),
                                        int'(next_want.orange_led));
                    if (res_ch.blue_led !== next_want.blue_led)
                        report_mismatch("blue_led", int'(res_ch.blue_led),
                                        int'(next_want.blue_led));
                    if (res_ch.mode !== next_want.mode)
                        report_mismatch("mode", int'(res_ch.mode), int'(next_want.mode));
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                sink_gap = pick_gap(sink_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        mismatch_cnt   = 0;
        idle_cycles    = 0;
        src_calm       = 1'b1;
        sink_calm      = 1'b0;
        rst_n          = 1'b0;
        wr_en          = 1'b0;
        wr_index       = REG_LONG_PRESS;
        wr_data        = '0;
        tick_ch.valid  = 1'b0;
        tick_ch.button = 1'b0;
        res_ch.ready   = 1'b0;
        reset_dimmer();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults: short tap toggles up to down and back
        hold_button(1'b1, 1);
        hold_button(1'b0, 1);
        hold_button(1'b1, 1);
        hold_button(1'b0, 1);

        // Fast timing, two steps: rise into max, release to down
        load_config(8'd2, 8'd1, 8'd1, 8'd1, 8'd2);
        hold_button(1'b1, 7);
        hold_button(1'b0, 1);
        // fall into min, release to up
        hold_button(1'b1, 5);
        hold_button(1'b0, 1);
        // release at the top in rise: stays until the next press goes to max
        hold_button(1'b1, 3);
        hold_button(1'b0, 2);
        hold_button(1'b1, 1);
        hold_button(1'b0, 1);
        // fall released above zero goes to down, then released at zero stays
        hold_button(1'b1, 2);
        hold_button(1'b0, 1);
        hold_button(1'b1, 2);
        hold_button(1'b0, 1);
        hold_button(1'b1, 1);
        hold_button(1'b0, 1);

        // Slowest settings: press counter saturates
        load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd15);
        hold_button(1'b1, 300);
        hold_button(1'b0, 2);
        hold_button(1'b1, 1);
        hold_button(1'b0, 2);

        // Long hold in down mode at level 0, which cannot fall, then shrink the range
        load_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd15);
        hold_button(1'b1, 25);
        hold_button(1'b0, 2);
        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd3);
        queue_presses(60);
        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_presses(40);

        // Random settings, mostly small periods
        repeat (8)
        begin
            load_config(pick_period(8), pick_period(4), pick_period(4), pick_period(3),
                        {4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))});
            queue_presses(150);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (dimmer_outputs_q.size() != 0)
            report_mismatch("results never returned", dimmer_outputs_q.size(), 0);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
